/* hdl/cc20_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the microcode program of the ChaCha20 core.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int PC_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef logic [15:0][31:0] words_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_0    = 3'd0,
		REG_KEY_1    = 3'd1,
		REG_KEY_2    = 3'd2,
		REG_KEY_3    = 3'd3,
		REG_NONCE_LO = 3'd4,
		REG_NONCE_HI = 3'd5,
		REG_INIT_CTR = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ROUND = 2'd1,
		OP_FINAL = 2'd2
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] line;
		logic       diag;
		logic       loop;
	} ucode_t;

	localparam logic [PC_W-1:0] LOOP_PC = 4'd1;

	// program: load, four column lines, four diagonal lines, loop, final add
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t uc;
		case (pc)
			4'd0:    uc = '{op: OP_LOAD,  line: 2'd0, diag: 1'b0, loop: 1'b0};
			4'd1:    uc = '{op: OP_ROUND, line: 2'd0, diag: 1'b0, loop: 1'b0};
			4'd2:    uc = '{op: OP_ROUND, line: 2'd1, diag: 1'b0, loop: 1'b0};
			4'd3:    uc = '{op: OP_ROUND, line: 2'd2, diag: 1'b0, loop: 1'b0};
			4'd4:    uc = '{op: OP_ROUND, line: 2'd3, diag: 1'b0, loop: 1'b0};
			4'd5:    uc = '{op: OP_ROUND, line: 2'd0, diag: 1'b1, loop: 1'b0};
			4'd6:    uc = '{op: OP_ROUND, line: 2'd1, diag: 1'b1, loop: 1'b0};
			4'd7:    uc = '{op: OP_ROUND, line: 2'd2, diag: 1'b1, loop: 1'b0};
			4'd8:    uc = '{op: OP_ROUND, line: 2'd3, diag: 1'b1, loop: 1'b1};
			4'd9:    uc = '{op: OP_FINAL, line: 2'd0, diag: 1'b0, loop: 1'b0};
			default: uc = '{op: OP_LOAD,  line: 2'd0, diag: 1'b0, loop: 1'b0};
		endcase
		return uc;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [1:0] line);
		logic [4:0] r;
		case (line)
			2'd0:    r = 5'd16;
			2'd1:    r = 5'd12;
			2'd2:    r = 5'd8;
			2'd3:    r = 5'd7;
			default: r = 5'd16;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
		return (v << n) | (v >> (6'd32 - {1'b0, n}));
	endfunction

	function automatic words_t init_words(input logic [255:0] key, input logic [95:0] nonce,
			input logic [31:0] ctr);
		words_t w;
		w[0] = 32'h61707865;
		w[1] = 32'h3320646e;
		w[2] = 32'h79622d32;
		w[3] = 32'h6b206574;
		for (int i = 0; i < 8; i++) begin
			w[4 + i] = key[32*i +: 32];
		end
		w[12] = ctr;
		for (int i = 0; i < 3; i++) begin
			w[13 + i] = nonce[32*i +: 32];
		end
		return w;
	endfunction

endpackage
`default_nettype wire

/* hdl/cc20_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_core
// Microcoded ChaCha20 block function: four quarter-round lanes, one line each step.
// ----------------------------------------------------------------------------
module cc20_core #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [255:0] key,
	input  wire logic [95:0] nonce,
	input  wire logic [31:0] ctr,
	input  wire logic [3:0]  rd_idx,
	output logic      [31:0] rd_word,
	output logic             done
);
	import cc20_pkg::*;

	localparam int RW = $clog2(DOUBLE_ROUNDS);
	localparam logic [RW-1:0] RND_LAST = RW'(DOUBLE_ROUNDS - 1);

	logic [PC_W-1:0] pc_q;
	logic [RW-1:0]   rnd_q;
	logic [31:0]     ctr_q;
	words_t          w_q;
	words_t          w_rnd;
	words_t          w_fin;
	words_t          init_w;
	ucode_t          uc;

	assign uc     = ucode_rom(pc_q);
	assign init_w = init_words(key, nonce, (uc.op == OP_LOAD) ? ctr : ctr_q);

	// one line of the four quarter rounds, column or diagonal
	always_comb begin
		logic [1:0]  lane;
		logic [1:0]  lb;
		logic [1:0]  lc;
		logic [1:0]  ld;
		logic [3:0]  xi;
		logic [3:0]  yi;
		logic [3:0]  zi;
		logic [31:0] sum;
		w_rnd = w_q;
		for (int l = 0; l < 4; l++) begin
			lane = 2'(l);
			lb   = lane + {1'b0, uc.diag};
			lc   = lane + {uc.diag, 1'b0};
			ld   = lane + {uc.diag, uc.diag};
			if (uc.line[0]) begin
				xi = {2'b10, lc};
				yi = {2'b11, ld};
				zi = {2'b01, lb};
			end else begin
				xi = {2'b00, lane};
				yi = {2'b01, lb};
				zi = {2'b11, ld};
			end
			sum       = w_q[xi] + w_q[yi];
			w_rnd[xi] = sum;
			w_rnd[zi] = rotl(w_q[zi] ^ sum, rot_amt(uc.line));
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			w_fin[i] = w_q[i] + init_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			rnd_q <= '0;
		end else begin
			case (uc.op)
				OP_LOAD: begin
					if (start) begin
						pc_q  <= LOOP_PC;
						rnd_q <= '0;
					end
				end
				OP_ROUND: begin
					if (uc.loop && (rnd_q != RND_LAST)) begin
						pc_q  <= LOOP_PC;
						rnd_q <= rnd_q + 1'b1;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				OP_FINAL: begin
					pc_q <= '0;
				end
				default: begin
					pc_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uc.op)
			OP_LOAD: begin
				if (start) begin
					w_q   <= init_w;
					ctr_q <= ctr;
				end
			end
			OP_ROUND: w_q <= w_rnd;
			OP_FINAL: w_q <= w_fin;
			default: ;
		endcase
	end

	assign done    = (uc.op == OP_FINAL);
	assign rd_word = w_q[rd_idx];

endmodule
`default_nettype wire

/* hdl/chacha20_stream_cipher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 byte stream cipher with a microcoded block generator.
// ----------------------------------------------------------------------------
// input channel in_valid/in_stall carries data_byte and end_of_message;
// output channel out_valid/out_stall carries out_byte and last_byte
// key, nonce and initial counter are set through cfg_write/cfg_index/cfg_data;
// the user must do so only while no item is in flight; the block does not enforce it
// a byte at offset 0 of a keystream block starts the block generator:
// one load, 8 steps per double round, one final add; out_valid for that
// item rises only after the final add has cleared wait_q and the byte is registered
// other bytes pass through the input and output registers; with no block to make,
// one item per cycle is sustained while the output is not stalled
// the generator's single shared round step sets the block time
// a stalled result stays in the output register; one more item is held
// inside, then in_stall rises until the result is taken
// reset clears the control and configuration registers and leaves the block
// idle, between messages, with the counter loaded from init_ctr_q on the next item
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              end_of_message,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [7:0]                             out_byte,
	output logic                                   last_byte
);
	import cc20_pkg::*;

	logic [3:0][63:0] key_q;
	logic [63:0]      nonce_lo_q;
	logic [31:0]      nonce_hi_q;
	logic [31:0]      init_ctr_q;

	logic [31:0] cnt_q;
	logic [5:0]  off_q;
	logic        in_msg_q;
	logic        pend_q;
	logic        wait_q;
	logic [5:0]  rd_off_q;
	logic [7:0]  data_q;
	logic        eom_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_byte_q;

	logic        fire;
	logic        accept;
	logic        need_blk;
	logic [5:0]  eff_off;
	logic [5:0]  off_inc;
	logic [31:0] eff_cnt;
	logic        start;
	logic        done;
	logic [31:0] rd_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			init_ctr_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_0:    key_q[0]   <= cfg_data;
				REG_KEY_1:    key_q[1]   <= cfg_data;
				REG_KEY_2:    key_q[2]   <= cfg_data;
				REG_KEY_3:    key_q[3]   <= cfg_data;
				REG_NONCE_LO: nonce_lo_q <= cfg_data;
				REG_NONCE_HI: nonce_hi_q <= cfg_data[31:0];
				REG_INIT_CTR: init_ctr_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign fire     = pend_q & ~wait_q & (~out_valid_q | ~out_stall);
	assign in_stall = pend_q & ~fire;
	assign accept   = in_valid & ~in_stall;

	assign eff_off  = in_msg_q ? off_q : 6'd0;
	assign eff_cnt  = in_msg_q ? cnt_q : init_ctr_q;
	assign need_blk = (eff_off == 6'd0);
	assign off_inc  = eff_off + 6'd1;
	assign start    = accept & need_blk;

	cc20_core #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.key     ({key_q[3], key_q[2], key_q[1], key_q[0]}),
		.nonce   ({nonce_hi_q, nonce_lo_q}),
		.ctr     (eff_cnt),
		.rd_idx  (rd_off_q[5:2]),
		.rd_word (rd_word),
		.done    (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			off_q       <= '0;
			in_msg_q    <= 1'b0;
			pend_q      <= 1'b0;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (end_of_message) begin
					off_q    <= '0;
					in_msg_q <= 1'b0;
				end else begin
					off_q    <= off_inc;
					in_msg_q <= 1'b1;
					cnt_q    <= (off_inc == 6'd0) ? eff_cnt + 32'd1 : eff_cnt;
				end
			end
			if (accept) begin
				pend_q <= 1'b1;
			end else if (fire) begin
				pend_q <= 1'b0;
			end
			if (start) begin
				wait_q <= 1'b1;
			end else if (done) begin
				wait_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_off_q <= eff_off;
			data_q   <= data_byte;
			eom_q    <= end_of_message;
		end
		if (fire) begin
			out_byte_q  <= data_q ^ rd_word[{rd_off_q[1:0], 3'b000} +: 8];
			last_byte_q <= eom_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_byte_q;

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-wide ChaCha20 stream cipher.
// Byte items go in through a queue-fed driver with random gaps. The output
// side stalls at random. Every accepted item is enciphered by a local
// ChaCha20 keystream generator. Each result is compared with the oldest
// outstanding prediction. Key, nonce and counter are rewritten between
// phases of the run, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_top;
	import cc20_pkg::*;

	localparam int DR = DOUBLE_ROUNDS_DEF;
	localparam int RANDOM_ITEMS = 1750;
	localparam int HOLD_CYCLES = 400;
	localparam int LIMIT_CYCLES = 1000000;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic [7:0] val;
		logic       eom;
	} plain_t;

	typedef struct packed {
		logic [7:0] val;
		logic       last;
	} cipher_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY_0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte = 8'h00;
	logic                  end_of_message = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            out_byte;
	logic                  last_byte;

	logic idle_on = 1'b1;
	logic hold_go = 1'b0;
	logic long_hold = 1'b0;

	plain_t  send_q [$];
	cipher_t cipher_due [$];
	int      bytes_queued = 0;
	int      bytes_taken = 0;
	int      fail_count = 0;
	int      cycle_count = 0;

	// local copy of the cipher state
	logic [63:0] key_q [4];
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q;
	logic [31:0] ctr_init_q;
	logic [7:0]  ks_buf [64];
	logic [31:0] ws [16];
	logic [31:0] blk_ctr;
	logic [5:0]  ks_pos;
	logic        msg_open;

	chacha20_stream_cipher #(
		.DOUBLE_ROUNDS(DR)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_byte(last_byte)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rol(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void qround(int a, int b, int c, int d);
		ws[a] = ws[a] + ws[b]; ws[d] = rol(ws[d] ^ ws[a], 16);
		ws[c] = ws[c] + ws[d]; ws[b] = rol(ws[b] ^ ws[c], 12);
		ws[a] = ws[a] + ws[b]; ws[d] = rol(ws[d] ^ ws[a], 8);
		ws[c] = ws[c] + ws[d]; ws[b] = rol(ws[b] ^ ws[c], 7);
	endfunction

	function automatic void refill_keystream();
		logic [31:0] seed [16];
		logic [31:0] sum;
		seed[0] = 32'h61707865;
		seed[1] = 32'h3320646e;
		seed[2] = 32'h79622d32;
		seed[3] = 32'h6b206574;
		for (int i = 0; i < 4; i++) begin
			seed[4 + 2 * i] = key_q[i][31:0];
			seed[5 + 2 * i] = key_q[i][63:32];
		end
		seed[12] = blk_ctr;
		seed[13] = nonce_lo_q[31:0];
		seed[14] = nonce_lo_q[63:32];
		seed[15] = nonce_hi_q;
		ws = seed;
		for (int r = 0; r < DR; r++) begin
			qround(0, 4, 8, 12);
			qround(1, 5, 9, 13);
			qround(2, 6, 10, 14);
			qround(3, 7, 11, 15);
			qround(0, 5, 10, 15);
			qround(1, 6, 11, 12);
			qround(2, 7, 8, 13);
			qround(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) begin
			sum = ws[i] + seed[i];
			ks_buf[4 * i]     = sum[7:0];
			ks_buf[4 * i + 1] = sum[15:8];
			ks_buf[4 * i + 2] = sum[23:16];
			ks_buf[4 * i + 3] = sum[31:24];
		end
	endfunction

	function automatic void encipher_byte(logic [7:0] d, logic eom);
		cipher_t res;
		if (!msg_open) begin
			blk_ctr = ctr_init_q;
			ks_pos = '0;
			msg_open = 1'b1;
		end
		if (ks_pos == 6'd0)
			refill_keystream();
		res.val = d ^ ks_buf[ks_pos];
		res.last = eom;
		cipher_due.push_back(res);
		ks_pos = ks_pos + 6'd1;
		if (ks_pos == 6'd0)
			blk_ctr = blk_ctr + 32'd1;
		if (eom) begin
			ks_pos = '0;
			msg_open = 1'b0;
		end
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
		case (idx)
			REG_KEY_0:    key_q[0] = v;
			REG_KEY_1:    key_q[1] = v;
			REG_KEY_2:    key_q[2] = v;
			REG_KEY_3:    key_q[3] = v;
			REG_NONCE_LO: nonce_lo_q = v;
			REG_NONCE_HI: nonce_hi_q = v[31:0];
			REG_INIT_CTR: ctr_init_q = v[31:0];
			default:      ;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("%0t ns: %s got %02h want %02h", $time, what, got, want);
		fail_count++;
	endtask

	// item driver
	int     gap_left = 0;
	plain_t nxt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				encipher_byte(data_byte, end_of_message);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (send_q.size() != 0 && idle_on && $urandom_range(0, 11) == 0) begin
					gap_left = $urandom_range(0, 16);
					in_valid <= 1'b0;
				end else if (send_q.size() != 0) begin
					nxt = send_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt.val;
					end_of_message <= nxt.eom;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	int      stall_left = 0;
	logic    burst;
	cipher_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cipher_due.size() == 0) begin
					report_mismatch("unexpected item", out_byte, 8'h00);
				end else begin
					want = cipher_due.pop_front();
					if (out_byte !== want.val)
						report_mismatch("out_byte", out_byte, want.val);
					if (last_byte !== want.last)
						report_mismatch("last_byte", {7'd0, last_byte}, {7'd0, want.last});
				end
			end
			burst = 1'b0;
			if (stall_left != 0) begin
				stall_left--;
				burst = 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 16);
				burst = 1'b1;
			end
			out_stall <= burst || long_hold;
		end
	end

	// long output hold-off so the block backs up into its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		apply_reg(idx, v);
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic push_item(logic [7:0] v, logic eom);
		plain_t it;
		it.val = v;
		it.eom = eom;
		send_q.push_back(it);
		bytes_queued++;
	endtask

	task automatic add_message(int len, logic close);
		for (int i = 0; i < len; i++)
			push_item(8'($urandom_range(0, 255)), close && (i == len - 1));
	endtask

	task automatic wait_quiet();
		while (!(bytes_taken == bytes_queued && cipher_due.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_value(logic is_ctr);
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0)
			return 64'h0;
		if (sel == 1)
			return 64'hFFFF_FFFF_FFFF_FFFF;
		if (sel == 2 && is_ctr)
			return {32'($urandom), 32'hFFFF_FFFF - 32'($urandom_range(0, 2))};
		return {32'($urandom), 32'($urandom)};
	endfunction

	function automatic int msg_len();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			return $urandom_range(1, 4);
		if (sel < 6)
			return $urandom_range(60, 70);
		if (sel < 9)
			return $urandom_range(1, 140);
		return $urandom_range(129, 200);
	endfunction

	task automatic scramble_regs();
		cfg_reg_t names [7] = '{REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3,
			REG_NONCE_LO, REG_NONCE_HI, REG_INIT_CTR};
		foreach (names[i])
			if ($urandom_range(0, 2) == 0)
				write_reg(names[i], pick_value(names[i] == REG_INIT_CTR));
		if ($urandom_range(0, 5) == 0)
			write_reg(REG_NONE, pick_value(1'b0));
		end_writes();
	endtask

	task automatic fill_phase(int target);
		int n;
		int len;
		n = 0;
		while (n < target) begin
			len = msg_len();
			n += len;
			add_message(len, (n < target) || ($urandom_range(0, 3) != 0));
		end
	endtask

	initial begin
		int rand_count;
		int mark;
		logic first;
		for (int i = 0; i < 4; i++)
			key_q[i] = '0;
		nonce_lo_q = '0;
		nonce_hi_q = '0;
		ctr_init_q = '0;
		blk_ctr = '0;
		ks_pos = '0;
		msg_open = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// registers at their reset values
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b1);
		push_item(8'h55, 1'b0);
		push_item(8'hAA, 1'b0);
		push_item(8'h0F, 1'b1);
		wait_quiet();

		// standard block-function key, nonce and counter
		write_reg(REG_KEY_0, 64'h0706_0504_0302_0100);
		write_reg(REG_KEY_1, 64'h0f0e_0d0c_0b0a_0908);
		write_reg(REG_KEY_2, 64'h1716_1514_1312_1110);
		write_reg(REG_KEY_3, 64'h1f1e_1d1c_1b1a_1918);
		write_reg(REG_NONCE_LO, 64'h4a00_0000_0900_0000);
		write_reg(REG_NONCE_HI, 64'h0);
		write_reg(REG_INIT_CTR, 64'h1);
		end_writes();
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(8'h7F, 1'b0);
		push_item(8'hFE, 1'b0);
		push_item(8'h33, 1'b0);
		push_item(8'hCC, 1'b1);
		wait_quiet();

		// all ones: counter wraps inside the message
		mark = bytes_queued;
		write_reg(REG_KEY_0, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_KEY_1, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_KEY_2, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_KEY_3, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_NONCE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_NONCE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_INIT_CTR, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_NONE, 64'h0123_4567_89AB_CDEF);
		end_writes();
		add_message(130, 1'b1);
		wait_quiet();

		// all zeros written explicitly
		write_reg(REG_KEY_0, 64'h0);
		write_reg(REG_KEY_1, 64'h0);
		write_reg(REG_KEY_2, 64'h0);
		write_reg(REG_KEY_3, 64'h0);
		write_reg(REG_NONCE_LO, 64'h0);
		write_reg(REG_NONCE_HI, 64'h0);
		write_reg(REG_INIT_CTR, 64'h0);
		end_writes();
		add_message(70, 1'b1);
		wait_quiet();
		rand_count = bytes_queued - mark;

		first = 1'b1;
		while (rand_count < RANDOM_ITEMS - 150) begin
			scramble_regs();
			idle_on <= ($urandom_range(0, 4) != 0);
			mark = bytes_queued;
			if (first) begin
				hold_go <= 1'b1;
				fill_phase(300);
			end else begin
				fill_phase($urandom_range(80, 220));
			end
			first = 1'b0;
			wait_quiet();
			rand_count += bytes_queued - mark;
		end

		// closing stretch at full rate on both sides
		scramble_regs();
		idle_on <= 1'b0;
		fill_phase(150);
		wait_quiet();
		repeat (100) @(posedge clk);

		if (fail_count == 0 && cipher_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
